### design/lsgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsgd_pkg;

    localparam int MAX_FEATURES        = 16;
    localparam int MAX_EXAMPLES        = 1024;
    localparam int SIGMOID_TABLE_DEPTH = 256;

    localparam int VALUE_W    = 24;
    localparam int TARGET_W   = 17;
    localparam int INDEX_W    = 4;
    localparam int EPOCH_W    = 16;
    localparam int NF_W       = 5;
    localparam int LR_W       = 16;
    localparam int TOL_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PROB_W     = 17;

    localparam logic [NF_W-1:0]    NF_RESET  = 5'd1;
    localparam logic [LR_W-1:0]    LR_RESET  = 16'd655;
    localparam logic [TOL_W-1:0]   TOL_RESET = 24'd168;
    localparam logic [EPOCH_W-1:0] ME_RESET  = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_FEATURES  = 2'd0,
        REG_LEARNING_RATE = 2'd1,
        REG_TOLERANCE     = 2'd2,
        REG_MAX_EPOCHS    = 2'd3
    } cfg_reg_t;

    // Restoring division, used only while the sigmoid table is built at elaboration.
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        int          b;
        begin
            rem = '0;
            quo = '0;
            for (b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // Entry k of the sigmoid table: the value at the bin midpoint, Q0.16.
    function automatic logic [PROB_W-1:0] sig_entry(input int unsigned k,
                                                    input int unsigned depth);
        logic [63:0] c_off;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] den;
        logic [63:0] s;
        logic        neg;
        int          it;
        begin
            c_off = long_div(64'(2 * k + 1) * 64'd524288, 64'(depth));
            if (c_off < 64'd524288)
            begin
                neg = 1'b1;
                a   = 64'd524288 - c_off;
            end
            else
            begin
                neg = 1'b0;
                a   = c_off - 64'd524288;
            end
            term = 64'd1 << 32;
            e    = '0;
            n    = '0;
            for (it = 0; it < 200; it++)
            begin
                if (term != 64'd0)
                begin
                    e    = e + term;
                    n    = n + 64'd1;
                    term = long_div(term * a, n << 16);
                end
            end
            den = e + (64'd1 << 32);
            s   = long_div(e * 64'd65536 + (den >> 1), den);
            if (neg)
                s = 64'd65536 - s;
            return s[PROB_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### design/lsgd_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsgd_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [lsgd_pkg::INDEX_W-1:0]         index;
    logic signed [lsgd_pkg::VALUE_W-1:0]  value;
    logic [lsgd_pkg::TARGET_W-1:0]        target;
    logic                                 last_of_example;
    logic                                 last_of_set;

    modport source (output valid, func, index, value, target, last_of_example, last_of_set,
                    input ready);
    modport sink   (input valid, func, index, value, target, last_of_example, last_of_set,
                    output ready);
endinterface

`default_nettype wire

### design/lsgd_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsgd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [lsgd_pkg::INDEX_W-1:0]         weight_index;
    logic signed [lsgd_pkg::VALUE_W-1:0]  weight;
    logic [lsgd_pkg::EPOCH_W-1:0]         epochs_used;
    logic                                 converged;
    logic                                 last;

    modport source (output valid, weight_index, weight, epochs_used, converged, last,
                    input ready);
    modport sink   (input valid, weight_index, weight, epochs_used, converged, last,
                    output ready);
endinterface

`default_nettype wire

### design/lsgd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lsgd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/lsgd_sigmoid.sv
`timescale 1ns / 1ps
`default_nettype none

module lsgd_sigmoid #(
    parameter int ACC_W = 53,
    parameter int DEPTH = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [ACC_W-1:0]           acc,
    output logic                                   done,
    output logic [lsgd_pkg::PROB_W-1:0]            h
);

    localparam int ZW     = ACC_W - 16;
    localparam int TI_W   = $clog2(DEPTH);
    localparam int IDXP_W = 20 + TI_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(32768);
    localparam logic signed [ZW-1:0]    ZLO  = ZW'(-524288);
    localparam logic signed [ZW-1:0]    ZHI  = ZW'(524288);

    logic [lsgd_pkg::PROB_W-1:0] rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        localparam logic [lsgd_pkg::PROB_W-1:0] ENTRY = lsgd_pkg::sig_entry(g, DEPTH);
        assign rom[g] = ENTRY;
    end

    logic signed [ACC_W-1:0] rnd;
    logic signed [ZW-1:0]    z;
    logic [IDXP_W-1:0]       idx_prod;

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    done_reg;
    logic                    lo_reg;
    logic                    hi_reg;
    logic [19:0]             zo_reg;
    logic [TI_W-1:0]         idx_reg;
    logic [lsgd_pkg::PROB_W-1:0] h_reg;

    assign rnd      = acc + HALF;
    assign z        = $signed(rnd[ACC_W-1:16]);
    assign idx_prod = IDXP_W'(zo_reg) * IDXP_W'(DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            lo_reg   <= 1'b0;
            hi_reg   <= 1'b0;
            zo_reg   <= '0;
            idx_reg  <= '0;
            h_reg    <= '0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
            lo_reg   <= (z < ZLO);
            hi_reg   <= (z >= ZHI);
            // Offsetting by 2^19 flips the top bit of the in-range value.
            zo_reg   <= {~z[19], z[18:0]};
            if (lo_reg)
                idx_reg <= '0;
            else if (hi_reg)
                idx_reg <= TI_W'(DEPTH - 1);
            else
                idx_reg <= idx_prod[IDXP_W-1:20];
            h_reg    <= rom[idx_reg];
        end
    end

    assign done = done_reg;
    assign h    = h_reg;

endmodule

`default_nettype wire

### design/logistic_sgd_trainer.sv
`timescale 1ns / 1ps
`default_nettype none

// Loading: one item per cycle, no result. The item with last_of_set starts training.
// Training: for each example and each unfrozen weight the dot product is streamed from the
// feature memory one word a cycle, then passed through the sigmoid and used to update that
// weight; frozen weights are skipped. The end-of-epoch tolerance sweep visits every weight.
// Results follow one weight at a time, each offered once the previous one is accepted.
// Reset clears the weights, frozen flags and counters; the stores are undefined until loaded.
module logistic_sgd_trainer #(
    parameter int MAX_FEATURES        = lsgd_pkg::MAX_FEATURES,
    parameter int MAX_EXAMPLES        = lsgd_pkg::MAX_EXAMPLES,
    parameter int SIGMOID_TABLE_DEPTH = lsgd_pkg::SIGMOID_TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [lsgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lsgd_pkg::CFG_DATA_W-1:0]   cfg_data,
    lsgd_item_if.sink                              item,
    lsgd_result_if.source                          result
);

    localparam int MF     = MAX_FEATURES;
    localparam int ME     = MAX_EXAMPLES;
    localparam int WI_W   = (MF > 1) ? $clog2(MF) : 1;
    localparam int CNT_W  = $clog2(MF + 1);
    localparam int FA_W   = (MF * ME > 1) ? $clog2(MF * ME) : 1;
    localparam int LA_W   = (ME > 1) ? $clog2(ME) : 1;
    localparam int EC_W   = $clog2(ME + 1);
    localparam int ACC_W  = 48 + $clog2(MF + 1);
    localparam int VW     = lsgd_pkg::VALUE_W;
    localparam int EW     = lsgd_pkg::EPOCH_W;
    localparam logic signed [58:0] HALF31 = 59'(64'd2147483648);
    localparam logic signed [27:0] W_MAX  = 28'(8388607);
    localparam logic signed [27:0] W_MIN  = 28'(-8388608);

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_START = 14'b00000000000010,
        S_EX    = 14'b00000000000100,
        S_LBL   = 14'b00000000001000,
        S_SKIP  = 14'b00000000010000,
        S_DOT   = 14'b00000000100000,
        S_DRAIN = 14'b00000001000000,
        S_SIG   = 14'b00000010000000,
        S_MUL   = 14'b00000100000000,
        S_UPD   = 14'b00001000000000,
        S_CV1   = 14'b00010000000000,
        S_CV2   = 14'b00100000000000,
        S_EPOCH = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [lsgd_pkg::NF_W-1:0]  nf_reg;
    logic [lsgd_pkg::LR_W-1:0]  lr_reg;
    logic [lsgd_pkg::TOL_W-1:0] tol_reg;
    logic [EW-1:0]              me_reg;

    // Weight state in flip-flops, read at the dot-product index or at the weight index i_reg
    logic signed [VW-1:0] weights_reg [MF];
    logic signed [VW-1:0] prev_reg    [MF];
    logic [MF-1:0]        frozen_reg;

    logic [EC_W-1:0]  count_reg;
    logic [FA_W-1:0]  load_base_reg;
    logic [EC_W-1:0]  j_reg;
    logic [FA_W-1:0]  base_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] k_reg;
    logic [WI_W-1:0]  kd_reg;
    logic [CNT_W-1:0] fin_reg;
    logic [EW-1:0]    epoch_reg;
    logic             conv_reg;

    logic                               rv_reg;
    logic                               rx_reg;
    logic                               pv_reg;
    logic signed [47:0]                 prod_dot_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [VW-1:0]               xi_reg;
    logic [lsgd_pkg::TARGET_W-1:0]      tgt_reg;
    logic signed [34:0]                 lre_reg;
    logic signed [58:0]                 prod_upd_reg;
    logic [24:0]                        diff_reg;
    logic [47:0]                        tolmag_reg;
    logic                               zero_reg;

    logic                               out_valid_reg;
    logic [lsgd_pkg::INDEX_W-1:0]       out_idx_reg;
    logic signed [VW-1:0]               out_w_reg;
    logic [EW-1:0]                      out_ep_reg;
    logic                               out_conv_reg;
    logic                               out_last_reg;

    // Combinational signals
    logic [CNT_W-1:0]  m_eff;
    logic [EW-1:0]     cap;
    logic [WI_W-1:0]   w_sel;
    logic signed [VW-1:0] w_rd;
    logic signed [VW-1:0] prev_rd;
    logic              frozen_rd;
    logic              in_fire;
    logic              out_fire;
    logic              idx_ok;
    logic              room;
    logic              feat_we;
    logic              lbl_we;
    logic [FA_W-1:0]   feat_waddr;
    logic [FA_W-1:0]   feat_raddr;
    logic [CNT_W-1:0]  rd_off;
    logic [VW-1:0]     feat_rdata;
    logic [lsgd_pkg::TARGET_W-1:0] lbl_rdata;
    logic              issue;
    logic              issue_x;
    logic              sig_start;
    logic              sig_done;
    logic [lsgd_pkg::PROB_W-1:0] sig_h;
    logic signed [17:0] err;
    logic signed [58:0] upd_rnd;
    logic signed [27:0] w_sum;
    logic signed [VW-1:0] w_sat;
    logic signed [25:0] wdiff;
    logic signed [24:0] p25;
    logic [23:0]        pmag;
    logic               meets;
    logic [EW:0]        epoch_inc;

    always_comb
    begin
        if (nf_reg == '0)
            m_eff = CNT_W'(1);
        else if (32'(nf_reg) > 32'(MF))
            m_eff = CNT_W'(MF);
        else
            m_eff = CNT_W'(nf_reg);
    end

    assign cap       = (me_reg == '0) ? EW'(1) : me_reg;
    assign w_sel     = ((state_reg == S_DOT) || (state_reg == S_DRAIN)) ? kd_reg
                                                                        : i_reg[WI_W-1:0];
    assign w_rd      = weights_reg[w_sel];
    assign prev_rd   = prev_reg[i_reg[WI_W-1:0]];
    assign frozen_rd = frozen_reg[i_reg[WI_W-1:0]];

    assign in_fire   = item.valid && item.ready;
    assign out_fire  = result.valid && result.ready;
    assign idx_ok    = (32'(item.index) < 32'(MF));
    assign room      = (count_reg < EC_W'(ME));
    assign feat_we   = in_fire && !item.func && room && idx_ok;
    assign lbl_we    = in_fire && !item.func && room
                       && (item.last_of_example || item.last_of_set);
    assign feat_waddr = load_base_reg + FA_W'(item.index);

    assign issue_x   = (state_reg == S_SKIP) && (i_reg < m_eff) && !frozen_rd;
    assign issue     = issue_x || (state_reg == S_DOT);
    assign rd_off    = (state_reg == S_SKIP) ? i_reg : k_reg;
    assign feat_raddr = base_reg + FA_W'(rd_off);
    assign sig_start = (state_reg == S_DRAIN) && !rv_reg && !pv_reg;

    assign err       = $signed({1'b0, tgt_reg}) - $signed({1'b0, sig_h});
    assign upd_rnd   = prod_upd_reg + HALF31;
    assign w_sum     = 28'(w_rd) + 28'($signed(upd_rnd[58:32]));
    assign w_sat     = (w_sum > W_MAX) ? VW'(W_MAX) :
                       (w_sum < W_MIN) ? VW'(W_MIN) : VW'(w_sum);

    assign wdiff     = 26'(w_rd) - 26'(prev_rd);
    assign p25       = 25'(prev_rd);
    assign pmag      = p25[24] ? 24'(-p25) : 24'(p25);
    // The zero-old case compares the absolute change alone against the tolerance.
    assign meets     = zero_reg ? ({diff_reg, 8'b0} < 33'(tol_reg))
                                : ({diff_reg, 24'b0} < 49'(tolmag_reg));
    assign epoch_inc = (EW + 1)'(epoch_reg) + (EW + 1)'(1);

    lsgd_ram #(
        .WIDTH (VW),
        .DEPTH (MF * ME)
    ) u_feat_ram (
        .clk     (clk),
        .wr_en   (feat_we),
        .wr_addr (feat_waddr),
        .wr_data (item.value),
        .rd_addr (feat_raddr),
        .rd_data (feat_rdata)
    );

    lsgd_ram #(
        .WIDTH (lsgd_pkg::TARGET_W),
        .DEPTH (ME)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (lbl_we),
        .wr_addr (count_reg[LA_W-1:0]),
        .wr_data (item.target),
        .rd_addr (j_reg[LA_W-1:0]),
        .rd_data (lbl_rdata)
    );

    lsgd_sigmoid #(
        .ACC_W (ACC_W),
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sigmoid (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sig_start),
        .acc   (acc_reg),
        .done  (sig_done),
        .h     (sig_h)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            nf_reg        <= lsgd_pkg::NF_RESET;
            lr_reg        <= lsgd_pkg::LR_RESET;
            tol_reg       <= lsgd_pkg::TOL_RESET;
            me_reg        <= lsgd_pkg::ME_RESET;
            for (int n = 0; n < MF; n++)
            begin
                weights_reg[n] <= '0;
                prev_reg[n]    <= '0;
            end
            frozen_reg    <= '0;
            count_reg     <= '0;
            load_base_reg <= '0;
            j_reg         <= '0;
            base_reg      <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            kd_reg        <= '0;
            fin_reg       <= '0;
            epoch_reg     <= '0;
            conv_reg      <= 1'b0;
            rv_reg        <= 1'b0;
            rx_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (lsgd_pkg::cfg_reg_t'(cfg_index))
                    lsgd_pkg::REG_NUM_FEATURES:  nf_reg  <= cfg_data[lsgd_pkg::NF_W-1:0];
                    lsgd_pkg::REG_LEARNING_RATE: lr_reg  <= cfg_data[lsgd_pkg::LR_W-1:0];
                    lsgd_pkg::REG_TOLERANCE:     tol_reg <= cfg_data[lsgd_pkg::TOL_W-1:0];
                    lsgd_pkg::REG_MAX_EPOCHS:    me_reg  <= cfg_data[EW-1:0];
                    default:                     ;
                endcase
            end

            // Dot-product stream: read data, then product, then accumulate.
            rv_reg <= issue;
            rx_reg <= issue_x;
            kd_reg <= k_reg[WI_W-1:0];
            pv_reg <= rv_reg && !rx_reg;
            if (issue_x)
                acc_reg <= '0;
            else if (pv_reg)
                acc_reg <= acc_reg + ACC_W'(prod_dot_reg);

            case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (item.func)
                        begin
                            if (idx_ok)
                                weights_reg[WI_W'(item.index)] <= item.value;
                        end
                        else if (room && (item.last_of_example || item.last_of_set))
                        begin
                            count_reg     <= count_reg + EC_W'(1);
                            load_base_reg <= load_base_reg + FA_W'(MF);
                        end
                        if (item.last_of_set)
                            state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    for (int n = 0; n < MF; n++)
                        prev_reg[n] <= weights_reg[n];
                    frozen_reg <= '0;
                    epoch_reg  <= '0;
                    j_reg      <= '0;
                    base_reg   <= '0;
                    conv_reg   <= 1'b0;
                    state_reg  <= S_EX;
                end
                S_EX:
                begin
                    i_reg <= '0;
                    if (j_reg == count_reg)
                    begin
                        fin_reg   <= '0;
                        state_reg <= S_CV1;
                    end
                    else
                        state_reg <= S_LBL;
                end
                S_LBL:
                begin
                    tgt_reg   <= lbl_rdata;
                    state_reg <= S_SKIP;
                end
                S_SKIP:
                begin
                    if (i_reg >= m_eff)
                    begin
                        j_reg     <= j_reg + EC_W'(1);
                        base_reg  <= base_reg + FA_W'(MF);
                        state_reg <= S_EX;
                    end
                    else if (frozen_rd)
                        i_reg <= i_reg + CNT_W'(1);
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DOT;
                    end
                end
                S_DOT:
                begin
                    k_reg <= k_reg + CNT_W'(1);
                    if (k_reg == m_eff - CNT_W'(1))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (sig_start)
                        state_reg <= S_SIG;
                end
                S_SIG:
                begin
                    if (sig_done)
                    begin
                        lre_reg   <= $signed({1'b0, lr_reg}) * err;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_upd_reg <= lre_reg * xi_reg;
                    state_reg    <= S_UPD;
                end
                S_UPD:
                begin
                    weights_reg[i_reg[WI_W-1:0]] <= w_sat;
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= S_SKIP;
                end
                S_CV1:
                begin
                    if (i_reg >= m_eff)
                        state_reg <= S_EPOCH;
                    else
                    begin
                        diff_reg   <= wdiff[25] ? 25'(-wdiff) : 25'(wdiff);
                        tolmag_reg <= tol_reg * pmag;
                        zero_reg   <= (prev_rd == '0);
                        state_reg  <= S_CV2;
                    end
                end
                S_CV2:
                begin
                    if (meets)
                    begin
                        frozen_reg[i_reg[WI_W-1:0]] <= 1'b1;
                        fin_reg <= fin_reg + CNT_W'(1);
                    end
                    prev_reg[i_reg[WI_W-1:0]] <= w_rd;
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= S_CV1;
                end
                S_EPOCH:
                begin
                    epoch_reg <= epoch_inc[EW-1:0];
                    i_reg     <= '0;
                    if (fin_reg >= m_eff)
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else if (epoch_inc >= (EW + 1)'(cap))
                        state_reg <= S_EMIT;
                    else
                    begin
                        j_reg     <= '0;
                        base_reg  <= '0;
                        state_reg <= S_EX;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= lsgd_pkg::INDEX_W'(i_reg);
                        out_w_reg     <= w_rd;
                        out_ep_reg    <= epoch_reg;
                        out_conv_reg  <= conv_reg;
                        out_last_reg  <= (i_reg == m_eff - CNT_W'(1));
                    end
                    else if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        i_reg         <= i_reg + CNT_W'(1);
                        if (out_last_reg)
                        begin
                            count_reg     <= '0;
                            load_base_reg <= '0;
                            state_reg     <= S_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    // Datapath registers of the dot-product stream need no reset.
    always_ff @(posedge clk)
    begin
        if (rv_reg && rx_reg)
            xi_reg <= $signed(feat_rdata);
        prod_dot_reg <= $signed(feat_rdata) * w_rd;
    end

    assign item.ready          = (state_reg == S_LOAD);
    assign result.valid        = out_valid_reg;
    assign result.weight_index = out_idx_reg;
    assign result.weight       = out_w_reg;
    assign result.epochs_used  = out_ep_reg;
    assign result.converged    = out_conv_reg;
    assign result.last         = out_last_reg;

    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_EMIT))
        else $error("result beat offered outside the emit phase");

    a_sig_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sig_done |-> (state_reg == S_SIG))
        else $error("sigmoid result arrived while the sequencer was not waiting");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= EC_W'(ME))
        else $error("example count beyond the store depth");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (i_reg < m_eff))
        else $error("emitted weight index beyond the features in use");

    a_no_dot_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIG) |-> (!rv_reg && !pv_reg))
        else $error("dot-product stream still busy while the sigmoid runs");

endmodule

`default_nettype wire
